[src/rmth_pkg.sv]
// Shared constants, types and helpers for the running median unit.
// Used by rmth_heap.sv and running_median_two_heaps_unit.sv; no dependencies.
package rmth_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int SAMPLE_W    = 16;
  localparam int HEAP_DEPTH  = (MAX_SAMPLES + 1) / 2;
  localparam int ADDR_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W       = $clog2(HEAP_DEPTH + 1);
  localparam int IDX_W       = CNT_W + 1;
  localparam int TOT_W       = $clog2(MAX_SAMPLES + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // command from the sequencer to one heap
  typedef struct packed {
    logic    start;
    logic    replace;   // 1: replace top and sift down, 0: insert and sift up
    sample_t value;
  } heap_cmd_t;

  // status of one heap
  typedef struct packed {
    logic             busy;
    sample_t          top;
    logic [CNT_W-1:0] count;
  } heap_stat_t;

  // a ranks strictly above b: greater in a max-heap, smaller in a min-heap
  function automatic logic ranks_above(sample_t a, sample_t b, logic is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

endpackage

[src/rmth_heap.sv]
// One binary heap held in a synchronous memory with two read ports.
// Depends on rmth_pkg.
module rmth_heap (
  input  logic               clk,
  input  logic               rst,
  input  logic               is_max,
  input  rmth_pkg::heap_cmd_t cmd,
  output rmth_pkg::heap_stat_t stat
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP_CHK = 3'd1;
  localparam logic [2:0] S_UP_CMP = 3'd2;
  localparam logic [2:0] S_DN_CHK = 3'd3;
  localparam logic [2:0] S_DN_CMP = 3'd4;

  rmth_pkg::sample_t mem [rmth_pkg::HEAP_DEPTH];

  logic [2:0]                 state;
  logic [rmth_pkg::IDX_W-1:0] idx;      // heap index, 1-based
  logic [rmth_pkg::CNT_W-1:0] count;
  rmth_pkg::sample_t          x;
  rmth_pkg::sample_t          top;
  rmth_pkg::sample_t          rd_a, rd_b;

  logic                        we;
  logic [rmth_pkg::ADDR_W-1:0] waddr, ra, rb;
  rmth_pkg::sample_t           wdata;

  logic [rmth_pkg::IDX_W-1:0] parent, child, child_b, sel;
  logic                        b_ok, take_b, move;
  rmth_pkg::sample_t           best;

  always_comb begin
    parent  = idx >> 1;
    child   = idx << 1;
    child_b = child + rmth_pkg::IDX_W'(1);
    b_ok    = child_b <= rmth_pkg::IDX_W'(count);
    take_b  = b_ok && rmth_pkg::ranks_above(rd_b, rd_a, is_max);
    best    = take_b ? rd_b : rd_a;
    sel     = take_b ? child_b : child;
    move    = 1'b0;
    we      = 1'b0;
    wdata   = x;
    waddr   = rmth_pkg::ADDR_W'(idx - rmth_pkg::IDX_W'(1));
    ra      = rmth_pkg::ADDR_W'(parent - rmth_pkg::IDX_W'(1));
    rb      = rmth_pkg::ADDR_W'(child);
    case (state)
      S_UP_CHK: begin
        we = (idx == rmth_pkg::IDX_W'(1));
      end
      S_UP_CMP: begin
        move = rmth_pkg::ranks_above(x, rd_a, is_max);
        we   = 1'b1;
        if (move) wdata = rd_a;
      end
      S_DN_CHK: begin
        ra = rmth_pkg::ADDR_W'(child - rmth_pkg::IDX_W'(1));
        we = child > rmth_pkg::IDX_W'(count);
      end
      S_DN_CMP: begin
        move = rmth_pkg::ranks_above(best, x, is_max);
        we   = 1'b1;
        if (move) wdata = best;
      end
      default: ;
    endcase
  end

  // heap storage: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  // cached copy of the root entry
  always_ff @(posedge clk) begin
    if (we && waddr == '0) top <= wdata;
  end

  // sift sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.start) begin
            x <= cmd.value;
            if (cmd.replace) begin
              idx   <= rmth_pkg::IDX_W'(1);
              state <= S_DN_CHK;
            end else begin
              idx   <= rmth_pkg::IDX_W'(count) + rmth_pkg::IDX_W'(1);
              count <= count + rmth_pkg::CNT_W'(1);
              state <= S_UP_CHK;
            end
          end
        end
        S_UP_CHK: state <= we ? S_IDLE : S_UP_CMP;
        S_UP_CMP: begin
          if (move) begin
            idx   <= parent;
            state <= S_UP_CHK;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DN_CHK: state <= we ? S_IDLE : S_DN_CMP;
        S_DN_CMP: begin
          if (move) begin
            idx   <= sel;
            state <= S_DN_CHK;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.busy  = (state != S_IDLE);
  assign stat.top   = top;
  assign stat.count = count;

endmodule

[src/running_median_two_heaps_unit.sv]
// Running lower median over a stream of signed samples, two heaps in memory.
// Depends on rmth_pkg and rmth_heap.
//
// Each accepted sample word yields one result word: the lower median of all
// stored samples, a dropped flag once 1024 samples are held, and the count.
// A max-heap of the lower half and a min-heap of the upper half each sit in
// a 512-entry memory; both sift in parallel, with a check state and a compare
// state per heap level, and the next sample is accepted only once both heaps
// are idle and the result is loaded. A result waits in an output register
// while the next sample is taken.
module running_median_two_heaps_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [rmth_pkg::SAMPLE_W-1:0] sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [rmth_pkg::SAMPLE_W-1:0] median,
  output logic                            dropped,
  output logic [rmth_pkg::TOT_W-1:0]      stored_count
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]           state;
  rmth_pkg::sample_t    x;
  logic                 drop;
  rmth_pkg::heap_cmd_t  lo_cmd, up_cmd;
  rmth_pkg::heap_stat_t lo_st, up_st;
  logic [rmth_pkg::TOT_W-1:0] total;

  rmth_heap u_lower (.clk(clk), .rst(rst), .is_max(1'b1), .cmd(lo_cmd), .stat(lo_st));
  rmth_heap u_upper (.clk(clk), .rst(rst), .is_max(1'b0), .cmd(up_cmd), .stat(up_st));

  assign total    = rmth_pkg::TOT_W'(lo_st.count) + rmth_pkg::TOT_W'(up_st.count);
  assign in_stall = (state != S_IDLE);

  // pick the heap operations for the new sample
  always_comb begin
    lo_cmd = '0;
    up_cmd = '0;
    if (state == S_RUN && !drop) begin
      if (lo_st.count == '0) begin
        lo_cmd = '{start: 1'b1, replace: 1'b0, value: x};
      end else if (lo_st.count == up_st.count) begin
        if (x < up_st.top) begin
          lo_cmd = '{start: 1'b1, replace: 1'b0, value: x};
        end else begin
          lo_cmd = '{start: 1'b1, replace: 1'b0, value: up_st.top};
          up_cmd = '{start: 1'b1, replace: 1'b1, value: x};
        end
      end else begin
        if (lo_st.top > x) begin
          lo_cmd = '{start: 1'b1, replace: 1'b1, value: x};
          up_cmd = '{start: 1'b1, replace: 1'b0, value: lo_st.top};
        end else begin
          up_cmd = '{start: 1'b1, replace: 1'b0, value: x};
        end
      end
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // S_FIN reloads the output word itself
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            x     <= sample;
            drop  <= total >= rmth_pkg::TOT_W'(rmth_pkg::MAX_SAMPLES);
            state <= S_RUN;
          end
        end
        S_RUN:  state <= S_WAIT;
        S_WAIT: if (!lo_st.busy && !up_st.busy) state <= S_FIN;
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            median       <= (lo_st.count == '0) ? '0 : lo_st.top;
            dropped      <= drop;
            stored_count <= total;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
